>>> hdl/task_profiler_slots_macros.svh
// ----------------------------------------------------------------------------
// task_profiler_slots_macros.svh
// assertion macros shared by the profiler checker
// ----------------------------------------------------------------------------
`ifndef TASK_PROFILER_SLOTS_MACROS_SVH
`define TASK_PROFILER_SLOTS_MACROS_SVH

// same-cycle implication, sampled on the rising clock edge, off during reset
`define TPS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("task_profiler_slots check failed");

// next-cycle implication, sampled on the rising clock edge, off during reset
`define TPS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("task_profiler_slots check failed");

`endif

>>> hdl/tps_pkg.sv
// ----------------------------------------------------------------------------
// tps_pkg
// codes, field widths and constants of the task profiler slot table
// ----------------------------------------------------------------------------
package tps_pkg;

  // field widths
  localparam int MODE_W   = 2;
  localparam int ID_W     = 4;
  localparam int STAMP_W  = 32;
  localparam int STATUS_W = 2;
  localparam int SLOT_W   = 4;
  localparam int DUR_W    = 32;
  localparam int RATE_W   = 20;
  localparam int COUNT_W  = 5;
  localparam int CPU_W    = 8;

  // shared serial divider
  localparam int DIV_W  = 32;
  localparam int DIV_CW = 5;
  localparam logic [DIV_CW-1:0] DIV_LAST = DIV_CW'(DIV_W - 1);

  // event modes
  localparam logic [MODE_W-1:0] MODE_REG   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_BEGIN = 2'd1;
  localparam logic [MODE_W-1:0] MODE_END   = 2'd2;
  localparam logic [MODE_W-1:0] MODE_READ  = 2'd3;

  // result status
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_UNREG = 2'd2;

  // constants
  localparam logic [DIV_W-1:0] RATE_NUM  = 32'd1000000;
  localparam logic [CPU_W-1:0] CPU_RESET = 8'd110;

endpackage

>>> hdl/task_profiler_slots.sv
// ----------------------------------------------------------------------------
// task_profiler_slots
// table of profiling slots fed by cycle-stamped register/begin/end/read events
// register, table full, unknown slot, empty read: result strobe in the cycle after transfer
// begin/end: result after two divisions (elapsed cycles to us, then rate)
// read all: one result per registered slot, each after its own rate division
// all divisions run on the one shared radix-2 divider, one at a time
// next transfer may start in the cycle of the last result; no receiver stall
// reset: slot count 0, cycles_per_us 110; slot memories cleared on register
// ----------------------------------------------------------------------------
module task_profiler_slots #(
  parameter int SLOTS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  output logic                           busy_o,
  input  logic [tps_pkg::MODE_W-1:0]     mode_i,
  input  logic [tps_pkg::ID_W-1:0]       slot_id_i,
  input  logic [tps_pkg::STAMP_W-1:0]    cycle_stamp_i,
  input  logic                           cfg_we_i,
  input  logic [tps_pkg::CPU_W-1:0]      cfg_wdata_i,
  output logic                           done_o,
  output logic [tps_pkg::STATUS_W-1:0]   status_o,
  output logic [tps_pkg::SLOT_W-1:0]     slot_out_o,
  output logic [tps_pkg::DUR_W-1:0]      duration_us_o,
  output logic [tps_pkg::RATE_W-1:0]     rate_hz_o,
  output logic [tps_pkg::COUNT_W-1:0]    entry_count_o,
  output logic                           last_o
);

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);
  localparam logic [CW-1:0] USED_MAX = CW'(SLOTS);

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD1,
    S_US_LD,
    S_US_DIV,
    S_US_WR,
    S_RD2,
    S_RT_LD,
    S_RT_DIV,
    S_EMIT
  } state_e;

  state_e                          state_q;
  logic [CW-1:0]                   used_q;
  logic [tps_pkg::CPU_W-1:0]       cpu_q;
  logic [tps_pkg::MODE_W-1:0]      mode_q;
  logic [IW-1:0]                   addr_q;
  logic [tps_pkg::STAMP_W-1:0]     stamp_q;

  // divider shift registers
  logic [tps_pkg::DIV_W-1:0]       rem_q;
  logic [tps_pkg::DIV_W-1:0]       quo_q;
  logic [tps_pkg::DIV_W-1:0]       dvs_q;
  logic [tps_pkg::DIV_CW-1:0]      cnt_q;

  // registered results
  logic                            done_q;
  logic [tps_pkg::STATUS_W-1:0]    status_q;
  logic [tps_pkg::SLOT_W-1:0]      slot_q;
  logic [tps_pkg::DUR_W-1:0]       dur_q;
  logic [tps_pkg::RATE_W-1:0]      rate_q;
  logic [tps_pkg::COUNT_W-1:0]     count_q;
  logic                            last_q;

  // slot memories
  logic [tps_pkg::STAMP_W-1:0]     start_mem [SLOTS];
  logic [tps_pkg::DUR_W-1:0]       run_mem   [SLOTS];
  logic [tps_pkg::DUR_W-1:0]       per_mem   [SLOTS];
  logic [tps_pkg::STAMP_W-1:0]     start_rd_q;
  logic [tps_pkg::DUR_W-1:0]       run_rd_q;
  logic [tps_pkg::DUR_W-1:0]       per_rd_q;

  logic                            start_we;
  logic                            run_we;
  logic                            per_we;
  logic [IW-1:0]                   wr_addr;
  logic [tps_pkg::STAMP_W-1:0]     start_wd;
  logic [tps_pkg::DUR_W-1:0]       run_wd;
  logic [tps_pkg::DUR_W-1:0]       per_wd;

  logic                            full;
  logic                            unreg;
  logic                            is_last;
  logic [tps_pkg::CPU_W-1:0]       cpu_eff;
  logic [tps_pkg::DIV_W:0]         rem_sh;
  logic [tps_pkg::DIV_W:0]         rem_sub;
  logic [tps_pkg::DIV_W-1:0]       rem_step;
  logic [tps_pkg::DIV_W-1:0]       quo_step;

  assign busy_o        = (state_q != S_IDLE);
  assign done_o        = done_q;
  assign status_o      = status_q;
  assign slot_out_o    = slot_q;
  assign duration_us_o = dur_q;
  assign rate_hz_o     = rate_q;
  assign entry_count_o = count_q;
  assign last_o        = last_q;

  // table and event checks
  assign full    = (used_q == USED_MAX);
  assign unreg   = (32'(slot_id_i) >= 32'(used_q));
  assign is_last = (mode_q != tps_pkg::MODE_READ) || ((CW'(addr_q) + CW'(1)) == used_q);
  assign cpu_eff = (cpu_q == '0) ? tps_pkg::CPU_W'(1) : cpu_q;

  // one restoring division step: dividend bits shift out of quo, quotient bits in
  assign rem_sh   = {rem_q, quo_q[tps_pkg::DIV_W-1]};
  assign rem_sub  = rem_sh - {1'b0, dvs_q};
  assign rem_step = rem_sub[tps_pkg::DIV_W] ? rem_sh[tps_pkg::DIV_W-1:0]
                                            : rem_sub[tps_pkg::DIV_W-1:0];
  assign quo_step = {quo_q[tps_pkg::DIV_W-2:0], ~rem_sub[tps_pkg::DIV_W]};

  // memory write select: clear on register, store quotient (and on begin the stamp) after first division
  always_comb begin
    start_we = 1'b0;
    run_we   = 1'b0;
    per_we   = 1'b0;
    wr_addr  = addr_q;
    start_wd = stamp_q;
    run_wd   = quo_q;
    per_wd   = quo_q;
    if (state_q == S_IDLE && start_i && mode_i == tps_pkg::MODE_REG && !full) begin
      start_we = 1'b1;
      run_we   = 1'b1;
      per_we   = 1'b1;
      wr_addr  = IW'(used_q);
      start_wd = '0;
      run_wd   = '0;
      per_wd   = '0;
    end else if (state_q == S_US_WR) begin
      if (mode_q == tps_pkg::MODE_BEGIN) begin
        per_we   = 1'b1;
        start_we = 1'b1;
      end else begin
        run_we = 1'b1;
      end
    end
  end

  // slot memories, registered read at the current slot
  always_ff @(posedge clk_i) begin
    if (start_we) begin
      start_mem[wr_addr] <= start_wd;
    end
    if (run_we) begin
      run_mem[wr_addr] <= run_wd;
    end
    if (per_we) begin
      per_mem[wr_addr] <= per_wd;
    end
    start_rd_q <= start_mem[addr_q];
    run_rd_q   <= run_mem[addr_q];
    per_rd_q   <= per_mem[addr_q];
  end

  // event capture, slot pointer and divider datapath
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          mode_q  <= mode_i;
          stamp_q <= cycle_stamp_i;
          addr_q  <= (mode_i == tps_pkg::MODE_READ) ? '0 : IW'(slot_id_i);
        end
      end
      S_US_LD: begin
        rem_q <= '0;
        quo_q <= stamp_q - start_rd_q;
        dvs_q <= tps_pkg::DIV_W'(cpu_eff);
        cnt_q <= '0;
      end
      S_RT_LD: begin
        rem_q <= '0;
        quo_q <= tps_pkg::RATE_NUM;
        dvs_q <= per_rd_q;
        cnt_q <= '0;
      end
      S_US_DIV, S_RT_DIV: begin
        rem_q <= rem_step;
        quo_q <= quo_step;
        cnt_q <= cnt_q + tps_pkg::DIV_CW'(1);
      end
      S_EMIT: begin
        if (!is_last) begin
          addr_q <= addr_q + IW'(1);
        end
      end
      default: ;
    endcase
  end

  // control sequence and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      used_q   <= '0;
      cpu_q    <= tps_pkg::CPU_RESET;
      done_q   <= 1'b0;
      status_q <= tps_pkg::ST_OK;
      slot_q   <= '0;
      dur_q    <= '0;
      rate_q   <= '0;
      count_q  <= '0;
      last_q   <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (cfg_we_i) begin
        cpu_q <= cfg_wdata_i;
      end
      unique case (state_q)
        S_IDLE: begin
          if (start_i) begin
            unique case (mode_i)
              tps_pkg::MODE_REG: begin
                done_q <= 1'b1;
                last_q <= 1'b1;
                dur_q  <= '0;
                rate_q <= '0;
                if (full) begin
                  status_q <= tps_pkg::ST_FULL;
                  slot_q   <= '0;
                  count_q  <= tps_pkg::COUNT_W'(used_q);
                end else begin
                  status_q <= tps_pkg::ST_OK;
                  slot_q   <= tps_pkg::SLOT_W'(used_q);
                  count_q  <= tps_pkg::COUNT_W'(used_q + CW'(1));
                  used_q   <= used_q + CW'(1);
                end
              end
              tps_pkg::MODE_READ: begin
                if (used_q == '0) begin
                  done_q   <= 1'b1;
                  last_q   <= 1'b1;
                  status_q <= tps_pkg::ST_OK;
                  slot_q   <= '0;
                  dur_q    <= '0;
                  rate_q   <= '0;
                  count_q  <= '0;
                end else begin
                  state_q <= S_RD2;
                end
              end
              tps_pkg::MODE_BEGIN, tps_pkg::MODE_END: begin
                if (unreg) begin
                  done_q   <= 1'b1;
                  last_q   <= 1'b1;
                  status_q <= tps_pkg::ST_UNREG;
                  slot_q   <= slot_id_i;
                  dur_q    <= '0;
                  rate_q   <= '0;
                  count_q  <= tps_pkg::COUNT_W'(used_q);
                end else begin
                  state_q <= S_RD1;
                end
              end
            endcase
          end
        end
        S_RD1:   state_q <= S_US_LD;
        S_US_LD: state_q <= S_US_DIV;
        S_US_DIV: begin
          if (cnt_q == tps_pkg::DIV_LAST) begin
            state_q <= S_US_WR;
          end
        end
        S_US_WR: state_q <= S_RD2;
        S_RD2:   state_q <= S_RT_LD;
        S_RT_LD: state_q <= S_RT_DIV;
        S_RT_DIV: begin
          if (cnt_q == tps_pkg::DIV_LAST) begin
            state_q <= S_EMIT;
          end
        end
        S_EMIT: begin
          // zero period reports zero rate
          done_q   <= 1'b1;
          status_q <= tps_pkg::ST_OK;
          slot_q   <= tps_pkg::SLOT_W'(addr_q);
          dur_q    <= run_rd_q;
          rate_q   <= (dvs_q == '0) ? '0 : quo_q[tps_pkg::RATE_W-1:0];
          count_q  <= tps_pkg::COUNT_W'(used_q);
          last_q   <= is_last;
          state_q  <= is_last ? S_IDLE : S_RD2;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

>>> hdl/tps_checker.sv
// ----------------------------------------------------------------------------
// tps_checker
// port-level checks of the profiler slot table, bound to the top level
// ----------------------------------------------------------------------------
`include "task_profiler_slots_macros.svh"

module tps_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic                          busy_o,
  input  logic                          done_o,
  input  logic [tps_pkg::STATUS_W-1:0]  status_o,
  input  logic [tps_pkg::DUR_W-1:0]     duration_us_o,
  input  logic [tps_pkg::RATE_W-1:0]    rate_hz_o,
  input  logic                          last_o
);

  // every transfer either answers at once or keeps the block busy
  `TPS_ASSERT_NEXT(a_accept_answered, start_i && !busy_o, busy_o || done_o)

  // more results of a read-all follow, so the block stays busy
  `TPS_ASSERT_NOW(a_more_keeps_busy, done_o && !last_o, busy_o)

  // going idle coincides with the final result
  `TPS_ASSERT_NOW(a_idle_on_last, $fell(busy_o), done_o && last_o)

  // error results carry no measurement and end the event
  `TPS_ASSERT_NOW(a_error_clean, done_o && (status_o != tps_pkg::ST_OK),
                  (duration_us_o == '0) && (rate_hz_o == '0) && last_o)

endmodule

bind task_profiler_slots tps_checker u_tps_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start_i       (start_i),
  .busy_o        (busy_o),
  .done_o        (done_o),
  .status_o      (status_o),
  .duration_us_o (duration_us_o),
  .rate_hz_o     (rate_hz_o),
  .last_o        (last_o)
);
